>>> hw/rtl/ppm_pkg.sv
// ----------------------------------------------------------------------------
// PPM stream parser package
// Shared types, result codes and character helpers for the PPM parser.
// ----------------------------------------------------------------------------
package ppm_pkg;

   localparam int DIM_BITS_DEF     = 16;
   localparam int SAMPLE_BITS_DEF  = 16;
   localparam int FIELD_BITS       = 16;
   localparam int ERR_BITS         = 4;
   localparam int PIXEL_COUNT_BITS = 32;
   localparam int QUEUE_DEPTH      = 4;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_PIXEL  = 2'd1,
      KIND_DONE   = 2'd2,
      KIND_ERROR  = 2'd3
   } kind_type;

   localparam logic [ERR_BITS-1:0] ERR_WIDTH_CHAR  = 4'd0;
   localparam logic [ERR_BITS-1:0] ERR_HEIGHT_CHAR = 4'd1;
   localparam logic [ERR_BITS-1:0] ERR_MAXV_CHAR   = 4'd2;
   localparam logic [ERR_BITS-1:0] ERR_MAGIC       = 4'd3;
   localparam logic [ERR_BITS-1:0] ERR_CONTENT     = 4'd4;
   localparam logic [ERR_BITS-1:0] ERR_PARTIAL_PIX = 4'd5;
   localparam logic [ERR_BITS-1:0] ERR_COUNT       = 4'd6;
   localparam logic [ERR_BITS-1:0] ERR_EOF_MAGIC   = 4'd7;
   localparam logic [ERR_BITS-1:0] ERR_OVERFLOW    = 4'd8;

   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_3     = 8'h33;
   localparam logic [7:0] CHAR_6     = 8'h36;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   typedef struct packed {
      kind_type                kind;
      logic [FIELD_BITS-1:0]   red;
      logic [FIELD_BITS-1:0]   green;
      logic [FIELD_BITS-1:0]   blue;
      logic [FIELD_BITS-1:0]   img_width;
      logic [FIELD_BITS-1:0]   img_height;
      logic [FIELD_BITS-1:0]   sample_max;
      logic                    binary_mode;
      logic [ERR_BITS-1:0]     error_code;
      logic                    last_of_run;
   } rsp_type;

   typedef struct packed {
      logic push_first;
      logic push_second;
   } push_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

endpackage

>>> hw/rtl/ppm_parse.sv
// ----------------------------------------------------------------------------
// PPM parse stage
// Input register followed by the combinational parser: header tokens, samples,
// pixel assembly and the end-of-stream checks. Produces up to two results.
// ----------------------------------------------------------------------------
module ppm_parse #(
   parameter int DIM_BITS    = ppm_pkg::DIM_BITS_DEF,
   parameter int SAMPLE_BITS = ppm_pkg::SAMPLE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data_byte,
   input  logic              req_end_of_stream,
   input  logic              room,
   output ppm_pkg::push_type push,
   output ppm_pkg::rsp_type  res_first,
   output ppm_pkg::rsp_type  res_second
);
   import ppm_pkg::*;

   localparam int AREA_BITS = 2 * DIM_BITS;
   localparam int CMP_BITS  = (AREA_BITS > PIXEL_COUNT_BITS) ? AREA_BITS : PIXEL_COUNT_BITS;

   typedef enum logic [5:0] {
      PH_MAGIC  = 6'b000001,
      PH_WIDTH  = 6'b000010,
      PH_HEIGHT = 6'b000100,
      PH_MAXV   = 6'b001000,
      PH_ASCII  = 6'b010000,
      PH_RAW    = 6'b100000
   } phase_type;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eos_ff;
   logic       advance;

   // parser state
   phase_type                   phase_ff, phase_in;
   logic                        open_ff, open_in;
   logic [1:0]                  mlen_ff, mlen_in;
   logic [7:0]                  mfirst_ff, mfirst_in;
   logic [7:0]                  msecond_ff, msecond_in;
   logic [DIM_BITS-1:0]         width_ff, width_in;
   logic [DIM_BITS-1:0]         height_ff, height_in;
   logic [SAMPLE_BITS-1:0]      maxv_ff, maxv_in;
   logic [SAMPLE_BITS-1:0]      accum_ff, accum_in;
   logic [1:0]                  chan_ff, chan_in;
   logic [SAMPLE_BITS-1:0]      red_ff, red_in;
   logic [SAMPLE_BITS-1:0]      green_ff, green_in;
   logic [PIXEL_COUNT_BITS-1:0] count_ff, count_in;
   logic                        hold_ff, hold_in;
   logic [AREA_BITS-1:0]        area_ff;

   // datapath helpers
   logic                        is_sp, is_dg;
   logic [3:0]                  dval;
   logic [DIM_BITS-1:0]         dim_acc;
   logic [DIM_BITS+3:0]         dim_ext, dim_next;
   logic                        dim_ovf;
   logic [SAMPLE_BITS-1:0]      smp_acc;
   logic [SAMPLE_BITS+3:0]      smp_ext, smp_next;
   logic                        smp_ovf;
   logic [SAMPLE_BITS+7:0]      raw_ext;
   logic [SAMPLE_BITS-1:0]      raw_smp;
   logic [PIXEL_COUNT_BITS-1:0] count_inc;
   logic                        take_pix_eos;
   logic [1:0]                  fin_chan;
   logic [PIXEL_COUNT_BITS-1:0] fin_count;
   logic [CMP_BITS+PIXEL_COUNT_BITS-1:0] fin_count_ext;
   logic [CMP_BITS+AREA_BITS-1:0]        area_ext;
   logic                        fin_match;
   logic                        is_raw;
   logic                        magic_p;
   rsp_type                     fin_rsp;
   logic                        take_smp;
   logic [SAMPLE_BITS-1:0]      take_val;
   logic                        restart_req;

   function automatic logic [FIELD_BITS-1:0] widen_dim(input logic [DIM_BITS-1:0] v);
      logic [FIELD_BITS+DIM_BITS-1:0] t;
      t = {{FIELD_BITS{1'b0}}, v};
      return t[FIELD_BITS-1:0];
   endfunction

   function automatic logic [FIELD_BITS-1:0] widen_smp(input logic [SAMPLE_BITS-1:0] v);
      logic [FIELD_BITS+SAMPLE_BITS-1:0] t;
      t = {{FIELD_BITS{1'b0}}, v};
      return t[FIELD_BITS-1:0];
   endfunction

   function automatic rsp_type make_error(input logic [ERR_BITS-1:0] code);
      rsp_type r;
      r            = '0;
      r.kind       = KIND_ERROR;
      r.error_code = code;
      return r;
   endfunction

   function automatic rsp_type make_pixel(input logic [SAMPLE_BITS-1:0] r_s,
                                          input logic [SAMPLE_BITS-1:0] g_s,
                                          input logic [SAMPLE_BITS-1:0] b_s,
                                          input logic bin);
      rsp_type r;
      r             = '0;
      r.kind        = KIND_PIXEL;
      r.red         = widen_smp(r_s);
      r.green       = widen_smp(g_s);
      r.blue        = widen_smp(b_s);
      r.binary_mode = bin;
      return r;
   endfunction

   // ---------------------------------------------------------------- input
   assign advance   = in_valid_ff && room;
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_eos_ff  <= req_end_of_stream;
      end
   end

   // ------------------------------------------------------------ datapath
   assign is_sp = is_space(in_byte_ff);
   assign is_dg = is_digit(in_byte_ff);
   assign dval  = in_byte_ff[3:0];

   // x*10 + d; any carry above the field width means overflow
   assign dim_acc  = (phase_ff == PH_WIDTH) ? width_ff : height_ff;
   assign dim_ext  = {4'b0000, dim_acc};
   assign dim_next = (dim_ext << 3) + (dim_ext << 1) + {{DIM_BITS{1'b0}}, dval};
   assign dim_ovf  = |dim_next[DIM_BITS+3:DIM_BITS];

   assign smp_acc  = (phase_ff == PH_MAXV) ? maxv_ff : accum_ff;
   assign smp_ext  = {4'b0000, smp_acc};
   assign smp_next = (smp_ext << 3) + (smp_ext << 1) + {{SAMPLE_BITS{1'b0}}, dval};
   assign smp_ovf  = |smp_next[SAMPLE_BITS+3:SAMPLE_BITS];

   assign raw_ext = {{SAMPLE_BITS{1'b0}}, in_byte_ff};
   assign raw_smp = raw_ext[SAMPLE_BITS-1:0];

   assign count_inc = (count_ff == '1) ? count_ff : count_ff + 1'b1;
   assign is_raw    = (phase_ff == PH_RAW);
   assign magic_p   = (mlen_ff == 2'd2) && (mfirst_ff == CHAR_P);

   // end of stream: an open P3 sample is taken before the final check
   assign take_pix_eos = (phase_ff == PH_ASCII) && open_ff && (chan_ff == 2'd2);
   always_comb begin
      fin_chan  = chan_ff;
      fin_count = count_ff;
      if ((phase_ff == PH_ASCII) && open_ff) begin
         fin_chan = (chan_ff == 2'd2) ? 2'd0 : chan_ff + 2'd1;
         if (chan_ff == 2'd2) begin
            fin_count = count_inc;
         end
      end
   end

   assign fin_count_ext = {{CMP_BITS{1'b0}}, fin_count};
   assign area_ext      = {{CMP_BITS{1'b0}}, area_ff};
   assign fin_match     = (fin_count_ext[CMP_BITS-1:0] == area_ext[CMP_BITS-1:0]);

   always_comb begin
      if (fin_chan != 2'd0) begin
         fin_rsp = make_error(ERR_PARTIAL_PIX);
      end else if (!fin_match) begin
         fin_rsp = make_error(ERR_COUNT);
      end else begin
         fin_rsp             = '0;
         fin_rsp.kind        = KIND_DONE;
         fin_rsp.binary_mode = is_raw;
      end
   end

   // ---------------------------------------------------------- next state
   always_comb begin
      phase_in    = phase_ff;
      open_in     = open_ff;
      mlen_in     = mlen_ff;
      mfirst_in   = mfirst_ff;
      msecond_in  = msecond_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      maxv_in     = maxv_ff;
      accum_in    = accum_ff;
      chan_in     = chan_ff;
      red_in      = red_ff;
      green_in    = green_ff;
      count_in    = count_ff;
      hold_in     = hold_ff;
      res_first   = '0;
      res_second  = '0;
      push        = '0;
      take_smp    = 1'b0;
      take_val    = raw_smp;
      restart_req = 1'b0;

      if (advance) begin
         if (hold_ff) begin
            // drop bytes until the end marker
            restart_req = in_eos_ff;
         end else if (in_eos_ff) begin
            restart_req     = 1'b1;
            push.push_first = 1'b1;
            unique case (phase_ff)
               PH_MAGIC:  res_first = make_error(ERR_EOF_MAGIC);
               PH_WIDTH:  res_first = make_error(ERR_WIDTH_CHAR);
               PH_HEIGHT: res_first = make_error(ERR_HEIGHT_CHAR);
               PH_MAXV:   res_first = make_error(ERR_MAXV_CHAR);
               PH_ASCII: begin
                  if (take_pix_eos) begin
                     res_first        = make_pixel(red_ff, green_ff, accum_ff, 1'b0);
                     res_second       = fin_rsp;
                     push.push_second = 1'b1;
                  end else begin
                     res_first = fin_rsp;
                  end
               end
               PH_RAW:    res_first = fin_rsp;
               default:   res_first = make_error(ERR_EOF_MAGIC);
            endcase
         end else begin
            unique case (phase_ff)
               PH_MAGIC: begin
                  if (is_sp) begin
                     if (open_ff) begin
                        open_in  = 1'b0;
                        phase_in = PH_WIDTH;
                     end
                  end else begin
                     if (mlen_ff == 2'd0) begin
                        mfirst_in = in_byte_ff;
                     end else if (mlen_ff == 2'd1) begin
                        msecond_in = in_byte_ff;
                     end
                     if (mlen_ff != 2'd3) begin
                        mlen_in = mlen_ff + 2'd1;
                     end
                     open_in = 1'b1;
                  end
               end
               PH_WIDTH, PH_HEIGHT: begin
                  if (is_sp) begin
                     if (open_ff) begin
                        open_in  = 1'b0;
                        phase_in = (phase_ff == PH_WIDTH) ? PH_HEIGHT : PH_MAXV;
                     end
                  end else if (is_dg && !dim_ovf) begin
                     open_in = 1'b1;
                     if (phase_ff == PH_WIDTH) begin
                        width_in = dim_next[DIM_BITS-1:0];
                     end else begin
                        height_in = dim_next[DIM_BITS-1:0];
                     end
                  end else begin
                     push.push_first = 1'b1;
                     hold_in         = 1'b1;
                     if (is_dg) begin
                        res_first = make_error(ERR_OVERFLOW);
                     end else if (phase_ff == PH_WIDTH) begin
                        res_first = make_error(ERR_WIDTH_CHAR);
                     end else begin
                        res_first = make_error(ERR_HEIGHT_CHAR);
                     end
                  end
               end
               PH_MAXV: begin
                  if (is_sp) begin
                     if (open_ff) begin
                        open_in         = 1'b0;
                        push.push_first = 1'b1;
                        if (magic_p && ((msecond_ff == CHAR_3) || (msecond_ff == CHAR_6))) begin
                           phase_in             = (msecond_ff == CHAR_6) ? PH_RAW : PH_ASCII;
                           res_first.kind       = KIND_HEADER;
                           res_first.img_width  = widen_dim(width_ff);
                           res_first.img_height = widen_dim(height_ff);
                           res_first.sample_max = widen_smp(maxv_ff);
                           res_first.binary_mode = (msecond_ff == CHAR_6);
                        end else begin
                           res_first = make_error(ERR_MAGIC);
                           hold_in   = 1'b1;
                        end
                     end
                  end else if (is_dg && !smp_ovf) begin
                     maxv_in = smp_next[SAMPLE_BITS-1:0];
                     open_in = 1'b1;
                  end else begin
                     push.push_first = 1'b1;
                     hold_in         = 1'b1;
                     res_first = make_error(is_dg ? ERR_OVERFLOW : ERR_MAXV_CHAR);
                  end
               end
               PH_ASCII: begin
                  if (is_dg && !smp_ovf) begin
                     accum_in = smp_next[SAMPLE_BITS-1:0];
                     open_in  = 1'b1;
                  end else if (is_sp) begin
                     if (open_ff) begin
                        open_in  = 1'b0;
                        accum_in = '0;
                        take_smp = 1'b1;
                        take_val = accum_ff;
                     end
                  end else begin
                     push.push_first = 1'b1;
                     hold_in         = 1'b1;
                     res_first = make_error(is_dg ? ERR_OVERFLOW : ERR_CONTENT);
                  end
               end
               PH_RAW: begin
                  take_smp = 1'b1;
               end
               default: begin
                  restart_req = 1'b1;
               end
            endcase

            // pixel assembly
            if (take_smp) begin
               if (chan_ff == 2'd0) begin
                  red_in  = take_val;
                  chan_in = 2'd1;
               end else if (chan_ff == 2'd1) begin
                  green_in = take_val;
                  chan_in  = 2'd2;
               end else begin
                  res_first       = make_pixel(red_ff, green_ff, take_val, is_raw);
                  push.push_first = 1'b1;
                  red_in          = '0;
                  green_in        = '0;
                  chan_in         = 2'd0;
                  count_in        = count_inc;
               end
            end
         end
      end

      if (restart_req) begin
         phase_in   = PH_MAGIC;
         open_in    = 1'b0;
         mlen_in    = '0;
         mfirst_in  = '0;
         msecond_in = '0;
         width_in   = '0;
         height_in  = '0;
         maxv_in    = '0;
         accum_in   = '0;
         chan_in    = '0;
         red_in     = '0;
         green_in   = '0;
         count_in   = '0;
         hold_in    = 1'b0;
      end

      res_first.last_of_run  = !push.push_second;
      res_second.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MAGIC;
         open_ff    <= 1'b0;
         mlen_ff    <= '0;
         mfirst_ff  <= '0;
         msecond_ff <= '0;
         width_ff   <= '0;
         height_ff  <= '0;
         maxv_ff    <= '0;
         accum_ff   <= '0;
         chan_ff    <= '0;
         red_ff     <= '0;
         green_ff   <= '0;
         count_ff   <= '0;
         hold_ff    <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         open_ff    <= open_in;
         mlen_ff    <= mlen_in;
         mfirst_ff  <= mfirst_in;
         msecond_ff <= msecond_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         maxv_ff    <= maxv_in;
         accum_ff   <= accum_in;
         chan_ff    <= chan_in;
         red_ff     <= red_in;
         green_ff   <= green_in;
         count_ff   <= count_in;
         hold_ff    <= hold_in;
      end
      // width and height settle several requests before content can end
      area_ff <= AREA_BITS'(width_ff) * AREA_BITS'(height_ff);
   end

endmodule

>>> hw/rtl/ppm_rsp_queue.sv
// ----------------------------------------------------------------------------
// PPM result queue
// Small result FIFO that takes up to two results per cycle and hands them
// out one per cycle on the result channel while rsp_ready is high.
// ----------------------------------------------------------------------------
module ppm_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  ppm_pkg::push_type push,
   input  ppm_pkg::rsp_type  res_first,
   input  ppm_pkg::rsp_type  res_second,
   output logic              room,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ppm_pkg::rsp_type  rsp_data
);
   import ppm_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = PTR_BITS + 1;

   rsp_type             queue_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [PTR_BITS-1:0] wr_next;
   logic                pop;
   logic [CNT_BITS-1:0] push_n;

   assign room      = (count_ff <= CNT_BITS'(QUEUE_DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = queue_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign wr_next   = wr_ptr_ff + 1'b1;

   always_comb begin
      push_n = '0;
      if (push.push_first) begin
         push_n = push.push_second ? CNT_BITS'(2) : CNT_BITS'(1);
      end
      wr_ptr_in = wr_ptr_ff + push_n[PTR_BITS-1:0];
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + push_n - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.push_first) begin
         queue_ff[wr_ptr_ff] <= res_first;
      end
      if (push.push_first && push.push_second) begin
         queue_ff[wr_next] <= res_second;
      end
   end

endmodule

>>> hw/rtl/ppm_stream_parser_top.sv
// ----------------------------------------------------------------------------
// PPM stream parser
// Byte-serial parser for P3 and P6 images with header, pixel and status
// results.
// ----------------------------------------------------------------------------
// Takes one file byte per request and sustains one request per clock while
// the result queue has room. A request is registered in the input register,
// parsed once the result queue has room, and its results are written into
// the result queue at the end of that cycle. Most requests give zero or one
// result; end of stream inside P3 content with an open sample that completes
// a pixel gives two (the last pixel, then the status). The four-entry result
// queue absorbs results while rsp_ready is low and holds off requests once
// fewer than two entries are free; the output drains one result per cycle
// while rsp_ready is high. The end marker also restarts the parser after an
// error. Width times height is computed by one registered multiplier as soon
// as the header values settle.
// ----------------------------------------------------------------------------
module ppm_stream_parser_top #(
   parameter int DIM_BITS    = ppm_pkg::DIM_BITS_DEF,
   parameter int SAMPLE_BITS = ppm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_end_of_stream,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output ppm_pkg::kind_type              rsp_out_kind,
   output logic [ppm_pkg::FIELD_BITS-1:0] rsp_red,
   output logic [ppm_pkg::FIELD_BITS-1:0] rsp_green,
   output logic [ppm_pkg::FIELD_BITS-1:0] rsp_blue,
   output logic [ppm_pkg::FIELD_BITS-1:0] rsp_img_width,
   output logic [ppm_pkg::FIELD_BITS-1:0] rsp_img_height,
   output logic [ppm_pkg::FIELD_BITS-1:0] rsp_sample_max,
   output logic                           rsp_binary_mode,
   output logic [ppm_pkg::ERR_BITS-1:0]   rsp_error_code,
   output logic                           rsp_last_of_run
);
   import ppm_pkg::*;

   push_type push;
   rsp_type  res_first;
   rsp_type  res_second;
   rsp_type  rsp_data;
   logic     room;

   ppm_parse #(
      .DIM_BITS    (DIM_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_parse (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .room              (room),
      .push              (push),
      .res_first         (res_first),
      .res_second        (res_second)
   );

   ppm_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .res_first  (res_first),
      .res_second (res_second),
      .room       (room),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_out_kind    = rsp_data.kind;
   assign rsp_red         = rsp_data.red;
   assign rsp_green       = rsp_data.green;
   assign rsp_blue        = rsp_data.blue;
   assign rsp_img_width   = rsp_data.img_width;
   assign rsp_img_height  = rsp_data.img_height;
   assign rsp_sample_max  = rsp_data.sample_max;
   assign rsp_binary_mode = rsp_data.binary_mode;
   assign rsp_error_code  = rsp_data.error_code;
   assign rsp_last_of_run = rsp_data.last_of_run;

endmodule

>>> hw/rtl/ppm_checker.sv
// ----------------------------------------------------------------------------
// PPM stream parser checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ppm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input ppm_pkg::kind_type              rsp_out_kind,
   input logic [ppm_pkg::FIELD_BITS-1:0] rsp_red,
   input logic [ppm_pkg::FIELD_BITS-1:0] rsp_green,
   input logic [ppm_pkg::FIELD_BITS-1:0] rsp_blue,
   input logic [ppm_pkg::FIELD_BITS-1:0] rsp_img_width,
   input logic                           rsp_binary_mode,
   input logic [ppm_pkg::ERR_BITS-1:0]   rsp_error_code,
   input logic                           rsp_last_of_run
);
   import ppm_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_kind)
         && $stable(rsp_blue) && $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   // only a pixel can precede the closing result of the same request
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=>
         rsp_valid && rsp_last_of_run && ($past(rsp_out_kind) == KIND_PIXEL))
      else $error("non-final result not followed by its final result");

   // samples are zero outside pixel results
   a_samples: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_kind != KIND_PIXEL) |->
         (rsp_red == '0) && (rsp_green == '0) && (rsp_blue == '0))
      else $error("sample data on a non-pixel result");

   // error results carry a known code, no mode and no image width
   a_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_kind == KIND_ERROR) |->
         !rsp_binary_mode && (rsp_error_code <= ERR_OVERFLOW) && (rsp_img_width == '0))
      else $error("malformed error result");

   // queue empties on reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind ppm_stream_parser_top ppm_checker u_ppm_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_kind    (rsp_out_kind),
   .rsp_red         (rsp_red),
   .rsp_green       (rsp_green),
   .rsp_blue        (rsp_blue),
   .rsp_img_width   (rsp_img_width),
   .rsp_binary_mode (rsp_binary_mode),
   .rsp_error_code  (rsp_error_code),
   .rsp_last_of_run (rsp_last_of_run)
);

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// PPM stream parser testbench
// Feeds P3/P6 byte streams (hand-written rows, then random well-formed,
// damaged and noise images) into the parser over a valid/ready request port.
// A behavioral parser in this module predicts every header, pixel, status
// and error result. Each result is checked field by field against that
// prediction under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ppm_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES     = 16;
   localparam int RANDOM_BYTES    = 1750;
   localparam int MAX_REPORTS     = 10;
   localparam longint unsigned DIM_LIMIT    = (64'd1 << DIM_BITS_DEF) - 1;
   localparam longint unsigned SAMPLE_LIMIT = (64'd1 << SAMPLE_BITS_DEF) - 1;
   localparam logic [ERR_BITS-1:0] NO_CODE = '0;

   typedef enum logic [2:0] {
      ST_MAGIC, ST_WIDTH, ST_HEIGHT, ST_MAXV, ST_ASCII, ST_RAW
   } parse_state_type;

   typedef struct packed {
      logic [7:0] data;
      logic       eos;
   } req_item_type;

   typedef struct packed {
      logic [7:0]          data;
      logic                eos;
      logic                typed;
      logic [ERR_BITS-1:0] err;
   } dir_row_type;

   // Rows marked typed carry the error result expected from that byte.
   dir_row_type dir_table [0:19] = '{
      '{8'hA5,      1'b1, 1'b1, ERR_EOF_MAGIC},
      '{CHAR_P,     1'b0, 1'b0, NO_CODE},
      '{CHAR_3,     1'b0, 1'b0, NO_CODE},
      '{CHAR_SPACE, 1'b0, 1'b0, NO_CODE},
      '{"a",        1'b0, 1'b1, ERR_WIDTH_CHAR},
      '{"z",        1'b0, 1'b0, NO_CODE},
      '{8'h00,      1'b1, 1'b0, NO_CODE},
      '{CHAR_P,     1'b0, 1'b0, NO_CODE},
      '{CHAR_6,     1'b0, 1'b0, NO_CODE},
      '{CHAR_TAB,   1'b0, 1'b0, NO_CODE},
      '{"1",        1'b0, 1'b0, NO_CODE},
      '{CHAR_CR,    1'b0, 1'b0, NO_CODE},
      '{"1",        1'b0, 1'b0, NO_CODE},
      '{CHAR_SPACE, 1'b0, 1'b0, NO_CODE},
      '{"9",        1'b0, 1'b0, NO_CODE},
      '{8'h0A,      1'b0, 1'b0, NO_CODE},
      '{8'h00,      1'b0, 1'b0, NO_CODE},
      '{8'hFF,      1'b0, 1'b0, NO_CODE},
      '{CHAR_SPACE, 1'b0, 1'b0, NO_CODE},
      '{8'hFF,      1'b1, 1'b0, NO_CODE}
   };

   logic                  clock             = 1'b0;
   logic                  reset             = 1'b1;
   logic                  req_valid         = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_data_byte     = 8'h00;
   logic                  req_end_of_stream = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready         = 1'b0;
   kind_type              rsp_out_kind;
   logic [FIELD_BITS-1:0] rsp_red;
   logic [FIELD_BITS-1:0] rsp_green;
   logic [FIELD_BITS-1:0] rsp_blue;
   logic [FIELD_BITS-1:0] rsp_img_width;
   logic [FIELD_BITS-1:0] rsp_img_height;
   logic [FIELD_BITS-1:0] rsp_sample_max;
   logic                  rsp_binary_mode;
   logic [ERR_BITS-1:0]   rsp_error_code;
   logic                  rsp_last_of_run;

   int   req_idle_pct = 26;
   int   rsp_idle_pct = 50;
   logic hold_active  = 1'b0;
   event rsp_hold_ev;
   int   cycle_count  = 0;
   int   fail_count   = 0;
   int   live_bytes   = 0;

   // parser model state
   parse_state_type parse_st;
   logic            tok_open;
   logic [1:0]      magic_len;
   logic [7:0]      magic_a;
   logic [7:0]      magic_b;
   longint unsigned dim_w;
   longint unsigned dim_h;
   longint unsigned max_val;
   longint unsigned sample_acc;
   logic [1:0]      chan;
   longint unsigned red_hold;
   longint unsigned green_hold;
   longint unsigned pix_count;
   logic            dropping;

   rsp_type      due_results [$];
   req_item_type gen_q [$];

   ppm_stream_parser_top i_dut (.*);

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- model

   function automatic bit blank_byte(input logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic bit decimal_byte(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic void clear_parser();
      parse_st   = ST_MAGIC;
      tok_open   = 1'b0;
      magic_len  = '0;
      magic_a    = '0;
      magic_b    = '0;
      dim_w      = 0;
      dim_h      = 0;
      max_val    = 0;
      sample_acc = 0;
      chan       = '0;
      red_hold   = 0;
      green_hold = 0;
      pix_count  = 0;
      dropping   = 1'b0;
   endfunction

   function automatic void add_result(input kind_type k,
                                      input longint unsigned r, g, b, w, h, m,
                                      input logic bin,
                                      input logic [ERR_BITS-1:0] err);
      rsp_type x;
      x.kind        = k;
      x.red         = r[FIELD_BITS-1:0];
      x.green       = g[FIELD_BITS-1:0];
      x.blue        = b[FIELD_BITS-1:0];
      x.img_width   = w[FIELD_BITS-1:0];
      x.img_height  = h[FIELD_BITS-1:0];
      x.sample_max  = m[FIELD_BITS-1:0];
      x.binary_mode = bin;
      x.error_code  = err;
      x.last_of_run = 1'b0;
      due_results = {due_results, x};
   endfunction

   function automatic void report_code(input logic [ERR_BITS-1:0] err);
      add_result(KIND_ERROR, 0, 0, 0, 0, 0, 0, 1'b0, err);
   endfunction

   function automatic void raise_error(input logic [ERR_BITS-1:0] err);
      report_code(err);
      dropping = 1'b1;
   endfunction

   function automatic void take_channel(input longint unsigned s, input logic bin);
      case (chan)
         2'd0: begin
            red_hold = s;
            chan     = 2'd1;
         end
         2'd1: begin
            green_hold = s;
            chan       = 2'd2;
         end
         default: begin
            add_result(KIND_PIXEL, red_hold, green_hold, s, 0, 0, 0, bin, NO_CODE);
            red_hold   = 0;
            green_hold = 0;
            chan       = '0;
            if (pix_count < 64'hFFFF_FFFF) pix_count++;
         end
      endcase
   endfunction

   function automatic void close_image(input logic bin);
      if (chan != 0) report_code(ERR_PARTIAL_PIX);
      else if (pix_count != dim_w * dim_h) report_code(ERR_COUNT);
      else add_result(KIND_DONE, 0, 0, 0, 0, 0, 0, bin, NO_CODE);
      clear_parser();
   endfunction

   function automatic void dim_char(input logic [7:0] c, input logic is_h);
      longint unsigned v;
      if (blank_byte(c)) begin
         if (tok_open) begin
            tok_open = 1'b0;
            parse_st = is_h ? ST_MAXV : ST_HEIGHT;
         end
      end else if (decimal_byte(c)) begin
         v = (is_h ? dim_h : dim_w) * 10 + (c - CHAR_ZERO);
         if (v > DIM_LIMIT) begin
            raise_error(ERR_OVERFLOW);
         end else begin
            if (is_h) dim_h = v;
            else dim_w = v;
            tok_open = 1'b1;
         end
      end else begin
         raise_error(is_h ? ERR_HEIGHT_CHAR : ERR_WIDTH_CHAR);
      end
   endfunction

   // Advance the parser model by one request; queue the results it causes.
   function automatic void parse_byte(input logic [7:0] c, input logic eos);
      int              n0;
      longint unsigned v;
      logic            pm;
      rsp_type         x;
      n0 = due_results.size();
      if (dropping) begin
         if (eos) clear_parser();
      end else if (eos) begin
         case (parse_st)
            ST_MAGIC: begin
               report_code(ERR_EOF_MAGIC);
               clear_parser();
            end
            ST_WIDTH: begin
               report_code(ERR_WIDTH_CHAR);
               clear_parser();
            end
            ST_HEIGHT: begin
               report_code(ERR_HEIGHT_CHAR);
               clear_parser();
            end
            ST_MAXV: begin
               report_code(ERR_MAXV_CHAR);
               clear_parser();
            end
            ST_ASCII: begin
               // an open sample counts before the final check
               if (tok_open) begin
                  tok_open = 1'b0;
                  take_channel(sample_acc, 1'b0);
                  sample_acc = 0;
               end
               close_image(1'b0);
            end
            default: close_image(1'b1);
         endcase
      end else begin
         case (parse_st)
            ST_MAGIC: begin
               if (blank_byte(c)) begin
                  if (tok_open) begin
                     tok_open = 1'b0;
                     parse_st = ST_WIDTH;
                  end
               end else begin
                  if (magic_len == 0) magic_a = c;
                  else if (magic_len == 1) magic_b = c;
                  if (magic_len < 3) magic_len++;
                  tok_open = 1'b1;
               end
            end
            ST_WIDTH:  dim_char(c, 1'b0);
            ST_HEIGHT: dim_char(c, 1'b1);
            ST_MAXV: begin
               if (blank_byte(c)) begin
                  if (tok_open) begin
                     pm       = (magic_len == 2) && (magic_a == CHAR_P);
                     tok_open = 1'b0;
                     if (pm && magic_b == CHAR_3) begin
                        parse_st = ST_ASCII;
                        add_result(KIND_HEADER, 0, 0, 0, dim_w, dim_h, max_val,
                                   1'b0, NO_CODE);
                     end else if (pm && magic_b == CHAR_6) begin
                        parse_st = ST_RAW;
                        add_result(KIND_HEADER, 0, 0, 0, dim_w, dim_h, max_val,
                                   1'b1, NO_CODE);
                     end else begin
                        raise_error(ERR_MAGIC);
                     end
                  end
               end else if (decimal_byte(c)) begin
                  v = max_val * 10 + (c - CHAR_ZERO);
                  if (v > SAMPLE_LIMIT) begin
                     raise_error(ERR_OVERFLOW);
                  end else begin
                     max_val  = v;
                     tok_open = 1'b1;
                  end
               end else begin
                  raise_error(ERR_MAXV_CHAR);
               end
            end
            ST_ASCII: begin
               if (decimal_byte(c)) begin
                  v = sample_acc * 10 + (c - CHAR_ZERO);
                  if (v > SAMPLE_LIMIT) begin
                     raise_error(ERR_OVERFLOW);
                  end else begin
                     sample_acc = v;
                     tok_open   = 1'b1;
                  end
               end else if (blank_byte(c)) begin
                  if (tok_open) begin
                     tok_open = 1'b0;
                     take_channel(sample_acc, 1'b0);
                     sample_acc = 0;
                  end
               end else begin
                  raise_error(ERR_CONTENT);
               end
            end
            default: take_channel(c, 1'b1);
         endcase
      end
      if (due_results.size() > n0) begin
         x = due_results[due_results.size() - 1];
         x.last_of_run = 1'b1;
         due_results[due_results.size() - 1] = x;
      end
   endfunction

   // ------------------------------------------------------------ generator

   function automatic void add_byte(input logic [7:0] b);
      req_item_type it;
      it.data = b;
      it.eos  = 1'b0;
      gen_q = {gen_q, it};
   endfunction

   function automatic void add_eos();
      req_item_type it;
      it.data = 8'($urandom_range(255));
      it.eos  = 1'b1;
      gen_q = {gen_q, it};
   endfunction

   function automatic void add_space(input int n);
      int k;
      repeat (n) begin
         k = $urandom_range(5);
         add_byte(k == 5 ? CHAR_SPACE : CHAR_TAB + 8'(k));
      end
   endfunction

   function automatic void add_decimal(input longint unsigned v);
      string s;
      s = $sformatf("%0d", v);
      if ($urandom_range(7) == 0) add_byte(CHAR_ZERO);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic logic [7:0] junk_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255));
      while (blank_byte(b) || decimal_byte(b));
      return b;
   endfunction

   // Build one image stream: mostly well formed, some damaged, some noise.
   function automatic void build_image(input bit long_p6);
      int              shape, w, h, mv, nsamp, ovf, cut, idx;
      bit              raw, open_end;
      longint unsigned sval;
      req_item_type    it;
      gen_q.delete();
      shape = long_p6 ? 99 : $urandom_range(99);
      if (shape < 10) begin
         repeat ($urandom_range(1, 16)) add_byte(8'($urandom_range(255)));
         add_eos();
         return;
      end
      raw = long_p6 || ($urandom_range(1) == 1);
      w   = long_p6 ? 4 : $urandom_range(4);
      h   = long_p6 ? 4 : $urandom_range(4);
      if (shape < 15) begin
         if ($urandom_range(1) == 1) begin
            w = int'(DIM_LIMIT);
            h = 0;
         end else begin
            w = 0;
            h = int'(DIM_LIMIT);
         end
      end
      case ($urandom_range(5))
         0:       mv = 0;
         1:       mv = 1;
         2:       mv = 255;
         3:       mv = int'(SAMPLE_LIMIT);
         default: mv = $urandom_range(2, 1000);
      endcase
      ovf = (shape >= 22 && shape < 28) ? $urandom_range(1, 4) : 0;

      if ($urandom_range(3) == 0) add_space($urandom_range(1, 2));
      if (shape >= 15 && shape < 22) begin
         case ($urandom_range(4))
            0: begin
               add_byte(CHAR_P);
               add_byte("5");
            end
            1: begin
               add_byte(CHAR_P);
               add_byte(CHAR_3);
               add_byte(CHAR_3);
            end
            2: begin
               add_byte("Q");
               add_byte(CHAR_3);
            end
            3: add_byte(CHAR_P);
            default: begin
               add_byte(junk_byte());
               add_byte(CHAR_6);
            end
         endcase
      end else begin
         add_byte(CHAR_P);
         add_byte(raw ? CHAR_6 : CHAR_3);
      end
      add_space($urandom_range(1, 3));
      add_decimal(ovf == 1 ? DIM_LIMIT + 1 + $urandom_range(99) : w);
      add_space($urandom_range(1, 2));
      add_decimal(ovf == 2 ? DIM_LIMIT + 1 + $urandom_range(99) : h);
      add_space($urandom_range(1, 2));
      add_decimal(ovf == 3 ? SAMPLE_LIMIT + 1 + $urandom_range(30000) : mv);
      // P6 takes exactly one separator before the raw samples
      add_space(raw ? 1 : $urandom_range(1, 2));

      nsamp = w * h * 3;
      if (shape >= 28 && shape < 34) begin
         case ($urandom_range(4))
            0:       nsamp -= 2;
            1:       nsamp -= 1;
            2:       nsamp += 1;
            3:       nsamp += 2;
            default: nsamp += 3;
         endcase
         if (nsamp < 0) nsamp = 0;
      end
      open_end = ($urandom_range(1) == 1);
      for (int i = 0; i < nsamp; i++) begin
         if (raw) begin
            add_byte(8'($urandom_range(255)));
         end else begin
            sval = ($urandom_range(7) == 0) ? $urandom_range(int'(SAMPLE_LIMIT))
                                            : $urandom_range(mv);
            if (ovf == 4 && i == nsamp / 2) sval = SAMPLE_LIMIT + 1 + $urandom_range(1000);
            add_decimal(sval);
            if (i < nsamp - 1 || !open_end) add_space($urandom_range(1, 2));
         end
      end

      if (shape >= 34 && shape < 40 && gen_q.size() != 0) begin
         idx     = $urandom_range(gen_q.size() - 1);
         it      = gen_q[idx];
         it.data = junk_byte();
         gen_q[idx] = it;
      end
      if (shape >= 40 && shape < 46) begin
         cut = $urandom_range(gen_q.size());
         while (gen_q.size() > cut) void'(gen_q.pop_back());
      end
      add_eos();
   endfunction

   // ------------------------------------------------------------- drivers

   task automatic push_byte(input logic [7:0] b, input logic eos);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_end_of_stream <= eos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!dropping) live_bytes++;
      parse_byte(b, eos);
   endtask

   task automatic send_stream();
      foreach (gen_q[i]) push_byte(gen_q[i].data, gen_q[i].eos);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_ready <= !hold_active && ($urandom_range(99) >= rsp_idle_pct);
   end

   // long receiver hold-off so the result queue backs up into the request side
   initial begin
      forever begin
         @(rsp_hold_ev);
         hold_active <= 1'b1;
         repeat (RSP_HOLD_CYCLES) @(posedge clock);
         hold_active <= 1'b0;
      end
   end

   // ------------------------------------------------------------- checking

   function automatic string rsp_text(input rsp_type r);
      return $sformatf("kind=%0d r=%0d g=%0d b=%0d w=%0d h=%0d max=%0d bin=%0b err=%0d last=%0b",
                       r.kind, r.red, r.green, r.blue, r.img_width, r.img_height,
                       r.sample_max, r.binary_mode, r.error_code, r.last_of_run);
   endfunction

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("%s", msg);
   endfunction

   always @(posedge clock) begin : result_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.kind        = rsp_out_kind;
         got.red         = rsp_red;
         got.green       = rsp_green;
         got.blue        = rsp_blue;
         got.img_width   = rsp_img_width;
         got.img_height  = rsp_img_height;
         got.sample_max  = rsp_sample_max;
         got.binary_mode = rsp_binary_mode;
         got.error_code  = rsp_error_code;
         got.last_of_run = rsp_last_of_run;
         if (due_results.size() == 0) begin
            note_failure($sformatf("unexpected result: %s", rsp_text(got)));
         end else begin
            want = due_results.pop_front();
            if (got.kind !== want.kind || got.red !== want.red ||
                got.green !== want.green || got.blue !== want.blue ||
                got.img_width !== want.img_width || got.img_height !== want.img_height ||
                got.sample_max !== want.sample_max ||
                got.binary_mode !== want.binary_mode ||
                got.error_code !== want.error_code ||
                got.last_of_run !== want.last_of_run) begin
               note_failure($sformatf("result mismatch at cycle %0d\n  exp %s\n  got %s",
                                      cycle_count, rsp_text(want), rsp_text(got)));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ppm_stream_parser_top verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------- stimulus

   initial begin : stimulus
      int      req_pcts [0:2] = '{26, 50, 0};
      int      rsp_pcts [0:2] = '{50, 26, 0};
      int      phase_end;
      rsp_type hand;
      clear_parser();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         push_byte(dir_table[i].data, dir_table[i].eos);
         if (dir_table[i].typed && due_results.size() != 0) begin
            hand             = '0;
            hand.kind        = KIND_ERROR;
            hand.error_code  = dir_table[i].err;
            hand.last_of_run = 1'b1;
            due_results[due_results.size() - 1] = hand;
         end
      end
      drain_results();

      // back up the result path while requests keep coming
      -> rsp_hold_ev;
      req_idle_pct = 0;
      build_image(1'b1);
      send_stream();
      drain_results();

      for (int p = 0; p < 3; p++) begin
         req_idle_pct = req_pcts[p];
         rsp_idle_pct = rsp_pcts[p];
         phase_end    = live_bytes + RANDOM_BYTES / 3;
         while (live_bytes < phase_end) begin
            build_image(1'b0);
            send_stream();
         end
         drain_results();
      end

      if (fail_count == 0) begin
         $display("ppm_stream_parser_top verification clean");
      end else begin
         $display("ppm_stream_parser_top verification failed");
      end
      $finish;
   end

endmodule
